FILE: rtl/rbsp_pkg.sv
// Shared types, constants and floating-point helpers for the ray/box slab picker.
package rbsp_pkg;

	typedef logic [31:0] fp32_t;

	localparam int NUM_AXES = 3;
	localparam int ADD_LAT  = 4;
	localparam int QUO_BITS = 25;
	localparam int DIV_LAT  = QUO_BITS + 4;
	localparam int SLAB_LAT = 4;
	localparam int PIPE_LAT = 2 * ADD_LAT + DIV_LAT + SLAB_LAT;
	localparam int FLAG_LAT = 2 * ADD_LAT + DIV_LAT;

	localparam fp32_t QNAN    = 32'h7FC0_0000;
	localparam fp32_t POS_INF = 32'h7F80_0000;

	// Configuration register indexes.
	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_DIR_X    = 3'd3;
	localparam logic [2:0] REG_DIR_Y    = 3'd4;
	localparam logic [2:0] REG_DIR_Z    = 3'd5;

	function automatic logic fp_is_nan(input fp32_t v);
		return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
	endfunction

	function automatic logic fp_is_inf(input fp32_t v);
		return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
	endfunction

	function automatic logic fp_is_zero(input fp32_t v);
		return v[30:0] == 31'd0;
	endfunction

	// Ordered less-than: false when either side is NaN, and +0 equals -0.
	function automatic logic fp_lt(input fp32_t a, input fp32_t b);
		logic res;
		if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_zero(a) && fp_is_zero(b))) begin
			res = 1'b0;
		end else if (a[31] != b[31]) begin
			res = a[31];
		end else if (!a[31]) begin
			res = a[30:0] < b[30:0];
		end else begin
			res = a[30:0] > b[30:0];
		end
		return res;
	endfunction

endpackage

FILE: rtl/rbsp_fadd.sv
// Four-stage single precision adder/subtractor with round to nearest even.
module rbsp_fadd
	import rbsp_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  fp32_t a,
	input  fp32_t b,
	input  logic  sub,
	output fp32_t y
);

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		logic       fnd;
		n   = 5'd27;
		fnd = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!fnd && v[i]) begin
				n   = 5'(26 - i);
				fnd = 1'b1;
			end
		end
		return n;
	endfunction

	// Stage A: order operands by magnitude and sort out special values.
	logic       sb_eff, a_big;
	fp32_t      big, sml;
	logic       sgn_big, sgn_sml;
	logic [7:0] eb_eff, es_eff;

	always_comb begin
		sb_eff  = b[31] ^ sub;
		a_big   = a[30:0] >= b[30:0];
		big     = a_big ? a : b;
		sml     = a_big ? b : a;
		sgn_big = a_big ? a[31] : sb_eff;
		sgn_sml = a_big ? sb_eff : a[31];
		eb_eff  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es_eff  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
	end

	logic        sgn_s1, same_s1, nan_s1, inf_s1, isgn_s1;
	logic [7:0]  exp_s1, diff_s1;
	logic [23:0] mbig_s1, msml_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1  <= sgn_big;
			same_s1 <= sgn_big == sgn_sml;
			exp_s1  <= eb_eff;
			diff_s1 <= eb_eff - es_eff;
			mbig_s1 <= {big[30:23] != 8'd0, big[22:0]};
			msml_s1 <= {sml[30:23] != 8'd0, sml[22:0]};
			nan_s1  <= fp_is_nan(a) || fp_is_nan(b) ||
				(fp_is_inf(a) && fp_is_inf(b) && (a[31] != sb_eff));
			inf_s1  <= fp_is_inf(a) || fp_is_inf(b);
			isgn_s1 <= fp_is_inf(a) ? a[31] : sb_eff;
		end
	end

	// Stage B: align the smaller operand, folding lost bits into sticky.
	logic [4:0]  shamt;
	logic [53:0] wide;
	logic [26:0] bal;

	always_comb begin
		shamt = (diff_s1 > 8'd27) ? 5'd27 : diff_s1[4:0];
		wide  = {msml_s1, 30'd0} >> shamt;
		bal   = {wide[53:28], wide[27] | (|wide[26:0])};
	end

	logic        sgn_s2, same_s2, nan_s2, inf_s2, isgn_s2;
	logic [7:0]  exp_s2;
	logic [26:0] abig_s2, bal_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s2  <= sgn_s1;
			same_s2 <= same_s1;
			exp_s2  <= exp_s1;
			abig_s2 <= {mbig_s1, 3'd0};
			bal_s2  <= bal;
			nan_s2  <= nan_s1;
			inf_s2  <= inf_s1;
			isgn_s2 <= isgn_s1;
		end
	end

	// Stage C: add or subtract magnitudes and count leading zeros.
	logic [27:0] sum;

	always_comb begin
		sum = same_s2 ? ({1'b0, abig_s2} + {1'b0, bal_s2}) :
			({1'b0, abig_s2} - {1'b0, bal_s2});
	end

	logic        sgn_s3, zsgn_s3, nan_s3, inf_s3, isgn_s3;
	logic [7:0]  exp_s3;
	logic [27:0] sum_s3;
	logic [4:0]  lz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s3  <= sgn_s2;
			zsgn_s3 <= same_s2 & sgn_s2;
			exp_s3  <= exp_s2;
			sum_s3  <= sum;
			lz_s3   <= lzc27(sum[26:0]);
			nan_s3  <= nan_s2;
			inf_s3  <= inf_s2;
			isgn_s3 <= isgn_s2;
		end
	end

	// Stage D: normalize, round to nearest even and pack.
	logic [8:0]  e_n, shl, emax;
	logic [26:0] nrm;
	logic        up;
	logic [24:0] m2;
	logic [8:0]  ef;
	logic [22:0] fr;
	fp32_t       res;

	always_comb begin
		emax = {1'b0, exp_s3} - 9'd1;
		shl  = ({4'd0, lz_s3} < emax) ? {4'd0, lz_s3} : emax;
		if (sum_s3[27]) begin
			nrm = {sum_s3[27:2], sum_s3[1] | sum_s3[0]};
			e_n = {1'b0, exp_s3} + 9'd1;
		end else begin
			nrm = sum_s3[26:0] << shl;
			e_n = {1'b0, exp_s3} - shl;
		end
		up = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
		m2 = {1'b0, nrm[26:3]} + {24'd0, up};
		if (m2[24]) begin
			ef = e_n + 9'd1;
			fr = 23'd0;
		end else begin
			ef = m2[23] ? e_n : 9'd0;
			fr = m2[22:0];
		end
		if (nan_s3) begin
			res = QNAN;
		end else if (inf_s3) begin
			res = {isgn_s3, POS_INF[30:0]};
		end else if (sum_s3 == 28'd0) begin
			res = {zsgn_s3, 31'd0};
		end else if (ef >= 9'd255) begin
			res = {sgn_s3, POS_INF[30:0]};
		end else begin
			res = {sgn_s3, ef[7:0], fr};
		end
	end

	fp32_t y_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			y_s4 <= res;
		end
	end

	assign y = y_s4;

endmodule

FILE: rtl/rbsp_fdiv.sv
// Pipelined single precision divider, one quotient bit per stage, round to nearest even.
module rbsp_fdiv
	import rbsp_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  fp32_t n,
	input  fp32_t d,
	output fp32_t q
);

	typedef struct packed {
		logic               sgn;
		logic               nan;
		logic               inf;
		logic               zro;
		logic signed [10:0] ex;
	} dctl_t;

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] c;
		logic       fnd;
		c   = 5'd24;
		fnd = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!fnd && v[i]) begin
				c   = 5'(23 - i);
				fnd = 1'b1;
			end
		end
		return c;
	endfunction

	// Stage 0: unpack, find subnormal shifts and classify special operands.
	logic [23:0] mn, md;
	logic [7:0]  en_eff, ed_eff;
	logic [4:0]  lzn, lzd;
	dctl_t       ctl0;

	always_comb begin
		mn      = {n[30:23] != 8'd0, n[22:0]};
		md      = {d[30:23] != 8'd0, d[22:0]};
		en_eff  = (n[30:23] == 8'd0) ? 8'd1 : n[30:23];
		ed_eff  = (d[30:23] == 8'd0) ? 8'd1 : d[30:23];
		lzn     = lzc24(mn);
		lzd     = lzc24(md);
		ctl0.sgn = n[31] ^ d[31];
		ctl0.nan = fp_is_nan(n) || fp_is_nan(d) || (fp_is_zero(n) && fp_is_zero(d)) ||
			(fp_is_inf(n) && fp_is_inf(d));
		ctl0.inf = fp_is_inf(n) || fp_is_zero(d);
		ctl0.zro = fp_is_zero(n) || fp_is_inf(d);
		ctl0.ex  = {3'd0, en_eff} - {6'd0, lzn} - {3'd0, ed_eff} + {6'd0, lzd};
	end

	logic [23:0] mn_s1, md_s1;
	logic [4:0]  lzn_s1, lzd_s1;
	dctl_t       ctl_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mn_s1  <= mn;
			md_s1  <= md;
			lzn_s1 <= lzn;
			lzd_s1 <= lzd;
			ctl_s1 <= ctl0;
		end
	end

	// Stage 1: normalize mantissas so the quotient lies in [1, 2).
	logic [23:0] mnn, mdn;
	logic        lt;
	dctl_t       ctl1;

	always_comb begin
		mnn     = mn_s1 << lzn_s1;
		mdn     = md_s1 << lzd_s1;
		lt      = mnn < mdn;
		ctl1    = ctl_s1;
		ctl1.ex = ctl_s1.ex + 11'sd127 - {10'd0, lt};
	end

	logic [24:0]         rem_s [QUO_BITS + 1];
	logic [23:0]         dvs_s [QUO_BITS + 1];
	logic [QUO_BITS-1:0] quo_s [QUO_BITS + 1];
	dctl_t               ctl_s [QUO_BITS + 1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= lt ? {mnn, 1'b0} : {1'b0, mnn};
			dvs_s[0] <= mdn;
			quo_s[0] <= '0;
			ctl_s[0] <= ctl1;
		end
	end

	// Restoring division: each stage settles one quotient bit.
	for (genvar k = 0; k < QUO_BITS; k++) begin : g_iter
		logic        ge;
		logic [24:0] nxt;

		always_comb begin
			ge  = rem_s[k] >= {1'b0, dvs_s[k]};
			nxt = ge ? (rem_s[k] - {1'b0, dvs_s[k]}) : rem_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= {nxt[23:0], 1'b0};
				dvs_s[k+1] <= dvs_s[k];
				quo_s[k+1] <= {quo_s[k][QUO_BITS-2:0], ge};
				ctl_s[k+1] <= ctl_s[k];
			end
		end
	end

	// Denormalize quotients that fall below the normal range.
	dctl_t               ctlf;
	logic                subn;
	logic signed [10:0]  rsh;
	logic [4:0]          dsh;
	logic [50:0]         dwide;
	logic [QUO_BITS-1:0] qsel;
	logic                stk;

	always_comb begin
		ctlf  = ctl_s[QUO_BITS];
		subn  = ctlf.ex < 11'sd1;
		rsh   = 11'sd1 - ctlf.ex;
		dsh   = (rsh > 11'sd26) ? 5'd26 : rsh[4:0];
		dwide = {quo_s[QUO_BITS], 26'd0} >> (subn ? dsh : 5'd0);
		qsel  = dwide[50:26];
		stk   = (rem_s[QUO_BITS] != 25'd0) | (|dwide[25:0]);
	end

	logic [QUO_BITS-1:0] qs_s28;
	logic                stk_s28, subn_s28;
	dctl_t               ctl_s28;

	always_ff @(posedge clk) begin
		if (en) begin
			qs_s28   <= qsel;
			stk_s28  <= stk;
			subn_s28 <= subn;
			ctl_s28  <= ctlf;
		end
	end

	// Round to nearest even and pack.
	logic               up;
	logic [24:0]        m2;
	logic signed [10:0] ef;
	logic [22:0]        fr;
	fp32_t              res;

	always_comb begin
		up = qs_s28[0] & (stk_s28 | qs_s28[1]);
		m2 = {1'b0, qs_s28[24:1]} + {24'd0, up};
		if (subn_s28) begin
			ef = {10'd0, m2[23]};
			fr = m2[22:0];
		end else if (m2[24]) begin
			ef = ctl_s28.ex + 11'sd1;
			fr = 23'd0;
		end else begin
			ef = ctl_s28.ex;
			fr = m2[22:0];
		end
		if (ctl_s28.nan) begin
			res = QNAN;
		end else if (ctl_s28.inf || (ef >= 11'sd255)) begin
			res = {ctl_s28.sgn, POS_INF[30:0]};
		end else if (ctl_s28.zro) begin
			res = {ctl_s28.sgn, 31'd0};
		end else begin
			res = {ctl_s28.sgn, ef[7:0], fr};
		end
	end

	fp32_t q_s29;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s29 <= res;
		end
	end

	assign q = q_s29;

endmodule

FILE: rtl/rbsp_slab.sv
// Slab interval narrowing over three axes, hit test and selection update.
module rbsp_slab
	import rbsp_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  fp32_t t_a [NUM_AXES],
	input  fp32_t t_b [NUM_AXES],
	input  logic  click,
	input  logic  was_selected,
	output logic  hit,
	output logic  selected,
	output fp32_t t_enter,
	output fp32_t t_exit
);

	// Stage 1: near and far plane per axis.
	fp32_t near_s1 [NUM_AXES];
	fp32_t far_s1  [NUM_AXES];
	logic  clk_s1, sel_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				near_s1[i] <= fp_lt(t_a[i], t_b[i]) ? t_a[i] : t_b[i];
				far_s1[i]  <= fp_lt(t_b[i], t_a[i]) ? t_a[i] : t_b[i];
			end
			clk_s1 <= click;
			sel_s1 <= was_selected;
		end
	end

	// Stage 2: combine the x and y intervals.
	fp32_t tin_s2, tout_s2, nz_s2, fz_s2;
	logic  clk_s2, sel_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			tin_s2  <= fp_lt(near_s1[1], near_s1[0]) ? near_s1[0] : near_s1[1];
			tout_s2 <= fp_lt(far_s1[0], far_s1[1]) ? far_s1[0] : far_s1[1];
			nz_s2   <= near_s1[2];
			fz_s2   <= far_s1[2];
			clk_s2  <= clk_s1;
			sel_s2  <= sel_s1;
		end
	end

	// Stage 3: narrow by the z interval.
	fp32_t tin_s3, tout_s3;
	logic  clk_s3, sel_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			tin_s3  <= fp_lt(nz_s2, tin_s2) ? tin_s2 : nz_s2;
			tout_s3 <= fp_lt(tout_s2, fz_s2) ? tout_s2 : fz_s2;
			clk_s3  <= clk_s2;
			sel_s3  <= sel_s2;
		end
	end

	// Stage 4: hit when exit is not below entry; NaNs leave as the quiet NaN.
	logic hit_c;

	always_comb begin
		hit_c = !fp_is_nan(tin_s3) && !fp_is_nan(tout_s3) && !fp_lt(tout_s3, tin_s3);
	end

	logic  hit_s4, sel_s4;
	fp32_t tin_s4, tout_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4  <= hit_c;
			sel_s4  <= clk_s3 ? hit_c : sel_s3;
			tin_s4  <= fp_is_nan(tin_s3) ? QNAN : tin_s3;
			tout_s4 <= fp_is_nan(tout_s3) ? QNAN : tout_s3;
		end
	end

	assign hit      = hit_s4;
	assign selected = sel_s4;
	assign t_enter  = tin_s4;
	assign t_exit   = tout_s4;

endmodule

FILE: rtl/ray_box_slab_pick.sv
// Top level of the ray/box slab picker: configuration, adders, dividers and slab test.
//
// Tests one axis-aligned box (center and half size, IEEE single precision)
// against the ray held in six configuration registers, using the chained slab
// method with round to nearest even and full subnormal support. The block is
// a fully pipelined datapath that accepts one transaction every clock cycle
// unless stalled; each input passes through two four-stage adders in series,
// a 29-stage divider that retires one quotient bit per stage, and four stages
// of min/max narrowing and hit test. A stall on the result side while a
// result is valid freezes the whole pipeline, and in_stall follows it in the
// same cycle. Configuration registers are to be written by the user only
// while no transaction is in flight; the block itself does not enforce this.
module ray_box_slab_pick
	import rbsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] box_center_x,
	input  logic [31:0] box_center_y,
	input  logic [31:0] box_center_z,
	input  logic [31:0] half_size_x,
	input  logic [31:0] half_size_y,
	input  logic [31:0] half_size_z,
	input  logic        click,
	input  logic        was_selected,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic        selected,
	output logic [31:0] t_enter,
	output logic [31:0] t_exit
);

	// Ray registers.
	fp32_t origin_q [NUM_AXES];
	fp32_t dir_q    [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				origin_q[i] <= '0;
				dir_q[i]    <= '0;
			end
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_q[0] <= cfg_data;
				REG_ORIGIN_Y: origin_q[1] <= cfg_data;
				REG_ORIGIN_Z: origin_q[2] <= cfg_data;
				REG_DIR_X:    dir_q[0]    <= cfg_data;
				REG_DIR_Y:    dir_q[1]    <= cfg_data;
				REG_DIR_Z:    dir_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline advances unless a finished result is held back.
	logic                en;
	logic [PIPE_LAT-1:0] vld_q;

	assign en        = !(vld_q[PIPE_LAT-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_valid};
		end
	end

	// Click and old selection mark travel beside the arithmetic.
	logic [1:0] flag_q [FLAG_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			flag_q[0] <= {click, was_selected};
			for (int i = 1; i < FLAG_LAT; i++) begin
				flag_q[i] <= flag_q[i-1];
			end
		end
	end

	// Per-axis plane distances.
	fp32_t center [NUM_AXES];
	fp32_t half   [NUM_AXES];
	fp32_t lo [NUM_AXES];
	fp32_t hi [NUM_AXES];
	fp32_t n1 [NUM_AXES];
	fp32_t n2 [NUM_AXES];
	fp32_t t1 [NUM_AXES];
	fp32_t t2 [NUM_AXES];

	assign center[0] = box_center_x;
	assign center[1] = box_center_y;
	assign center[2] = box_center_z;
	assign half[0]   = half_size_x;
	assign half[1]   = half_size_y;
	assign half[2]   = half_size_z;

	for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
		rbsp_fadd u_lo (.clk(clk), .en(en), .a(center[ax]), .b(half[ax]), .sub(1'b1),
			.y(lo[ax]));
		rbsp_fadd u_hi (.clk(clk), .en(en), .a(center[ax]), .b(half[ax]), .sub(1'b0),
			.y(hi[ax]));
		rbsp_fadd u_n1 (.clk(clk), .en(en), .a(lo[ax]), .b(origin_q[ax]), .sub(1'b1),
			.y(n1[ax]));
		rbsp_fadd u_n2 (.clk(clk), .en(en), .a(hi[ax]), .b(origin_q[ax]), .sub(1'b1),
			.y(n2[ax]));
		rbsp_fdiv u_t1 (.clk(clk), .en(en), .n(n1[ax]), .d(dir_q[ax]), .q(t1[ax]));
		rbsp_fdiv u_t2 (.clk(clk), .en(en), .n(n2[ax]), .d(dir_q[ax]), .q(t2[ax]));
	end

	// Interval narrowing and hit test; its last stage is the output register.
	rbsp_slab u_slab (
		.clk          (clk),
		.en           (en),
		.t_a          (t1),
		.t_b          (t2),
		.click        (flag_q[FLAG_LAT-1][1]),
		.was_selected (flag_q[FLAG_LAT-1][0]),
		.hit          (hit),
		.selected     (selected),
		.t_enter      (t_enter),
		.t_exit       (t_exit)
	);

endmodule
